@@ rtl/bht_pkg.sv @@
// Package for the bucketed hash table: sizes, operation and status codes,
// request/response item structs and sequencer states. No dependencies.
`default_nettype none

package bht_pkg;

	localparam int NUM_BUCKETS = 256;
	localparam int WAYS        = 4;
	localparam int SLOT_COUNT  = NUM_BUCKETS * WAYS;
	localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WAY_CW      = $clog2(WAYS + 1);
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int ENTRY_W     = 1 + KEY_W + VAL_W;

	typedef enum logic [1:0] {
		FN_LOOKUP = 2'd0,
		FN_UPDATE = 2'd1,
		FN_INSERT = 2'd2,
		FN_ERASE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_PRESENT   = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		func_t              func;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   read_value;
	} rsp_t;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
	} entry_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ACT
	} state_t;

	// first slot of the key's bucket
	function automatic logic [SLOT_W-1:0] bucket_base(input logic [KEY_W-1:0] key);
		logic [KEY_W-1:0] bkt;
		bkt = key % NUM_BUCKETS;
		return SLOT_W'(bkt * WAYS);
	endfunction

endpackage

`default_nettype wire

@@ rtl/bucketed_hash_table.sv @@
// Bucketed key-value table: sequencer, one shared key comparator, slot RAM.
// Depends on bht_pkg and bht_ram.
//
// channel   signals                 dir  accepted when
// request   start, busy, req        in   start && !busy at clk rise
// response  done, rsp               out  done high (one cycle, no stall)
//
// Each item scans its bucket: one read per way through the single RAM read
// port, each compared by the one key comparator, then a decide state that
// writes back where needed. The response strobe follows in the next cycle.
// After reset a clearing pass writes every slot invalid, with busy high.
// The receiver cannot stall; nothing is held back.
`default_nettype none

module bucketed_hash_table
	import bht_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	state_t              state_q, state_d;
	req_t                req_q;
	logic [SLOT_W-1:0]   base_q;
	logic [WAY_CW-1:0]   rd_way_q;
	logic [WAY_W-1:0]    cmp_way_q;
	logic                hit_q, free_q;
	logic [WAY_W-1:0]    hit_way_q, free_way_q;
	logic [VAL_W-1:0]    hit_val_q;
	logic [SLOT_W-1:0]   clr_q;
	logic                done_q;
	rsp_t                rsp_q, rsp_d;

	logic                accept;
	logic                ram_we, ram_re;
	logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
	entry_t              ram_wdata, ram_rdata;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;

	bht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == SLOT_W'(SLOT_COUNT - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (cmp_way_q == WAY_W'(WAYS - 1)) state_d = S_ACT;
			end
			S_ACT: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: RAM ports and response
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = base_q + SLOT_W'(rd_way_q);
		ram_we    = 1'b0;
		ram_waddr = base_q + SLOT_W'(hit_way_q);
		ram_wdata = '{valid: 1'b1, key: req_q.key, value: req_q.value};
		rsp_d     = '{status: STAT_OK, read_value: '0};
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				ram_re    = start;
				ram_raddr = bucket_base(req.key);
			end
			S_SCAN: begin
				ram_re = (rd_way_q < WAY_CW'(WAYS));
			end
			S_ACT: begin
				unique case (req_q.func)
					FN_LOOKUP: begin
						if (hit_q) rsp_d.read_value = hit_val_q;
						else       rsp_d.status     = STAT_NOT_FOUND;
					end
					FN_UPDATE: begin
						if (hit_q) ram_we       = 1'b1;
						else       rsp_d.status = STAT_NOT_FOUND;
					end
					FN_INSERT: begin
						ram_waddr = base_q + SLOT_W'(free_way_q);
						if (hit_q)        rsp_d.status = STAT_PRESENT;
						else if (!free_q) rsp_d.status = STAT_FULL;
						else              ram_we       = 1'b1;
					end
					FN_ERASE: begin
						ram_wdata.valid = 1'b0;
						if (hit_q) ram_we       = 1'b1;
						else       rsp_d.status = STAT_NOT_FOUND;
					end
					default: rsp_d.status = STAT_NOT_FOUND;
				endcase
			end
			default: ram_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_ACT);
			if (state_q == S_CLEAR) clr_q <= clr_q + SLOT_W'(1);
		end
	end

	// item context and scan results
	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (accept) begin
			req_q     <= req;
			base_q    <= bucket_base(req.key);
			rd_way_q  <= WAY_CW'(1);
			cmp_way_q <= '0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
		end else if (state_q == S_SCAN) begin
			if (ram_re) rd_way_q <= rd_way_q + WAY_CW'(1);
			cmp_way_q <= cmp_way_q + WAY_W'(1);
			if (ram_rdata.valid) begin
				if (!hit_q && ram_rdata.key == req_q.key) begin
					hit_q     <= 1'b1;
					hit_way_q <= cmp_way_q;
					hit_val_q <= ram_rdata.value;
				end
			end else if (!free_q) begin
				free_q     <= 1'b1;
				free_way_q <= cmp_way_q;
			end
		end
	end

	a_done_after_act: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == S_ACT)
		else $error("response strobe without a decide cycle");

	a_accept_scans: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SCAN)
		else $error("accepted item did not start a scan");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_IDLE) |-> !ram_we)
		else $error("slot write outside clear or decide cycle");

	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.status != STAT_OK) |-> rsp_q.read_value == '0)
		else $error("nonzero value on an error status");

endmodule

`default_nettype wire

@@ rtl/bht_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
